/* rtl/core/repc_pkg.sv */
`timescale 1ns / 1ps
package repc_pkg;
    localparam int MAX_POSITIONS  = 512;
    localparam int QUALITY_LEVELS = 64;
    localparam int COUNT_WIDTH    = 32;
    localparam int BASE_CODES     = 5;
    localparam int PAIR_CODES     = BASE_CODES * BASE_CODES;
    localparam int POS_W          = $clog2(MAX_POSITIONS + 1);
    localparam int PIDX_W         = $clog2(MAX_POSITIONS);
    localparam int QUAL_W         = $clog2(QUALITY_LEVELS);

    localparam int TOT_DEPTH  = 2 * MAX_POSITIONS;
    localparam int QUAL_DEPTH = 2 * MAX_POSITIONS * QUALITY_LEVELS;
    localparam int SUB_DEPTH  = 2 * PAIR_CODES;
    localparam int PSUB_DEPTH = 2 * MAX_POSITIONS * PAIR_CODES;
    localparam int TOT_AW  = $clog2(TOT_DEPTH);
    localparam int QUAL_AW = $clog2(QUAL_DEPTH);
    localparam int SUB_AW  = $clog2(SUB_DEPTH);
    localparam int PSUB_AW = $clog2(PSUB_DEPTH);
    // longest memory sets the clear sweep
    localparam int CLR_DEPTH = QUAL_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH + 1);

    localparam logic [2:0] KIND_TOTAL = 3'd0;
    localparam logic [2:0] KIND_ERROR = 3'd1;
    localparam logic [2:0] KIND_CQUAL = 3'd2;
    localparam logic [2:0] KIND_EQUAL = 3'd3;
    localparam logic [2:0] KIND_SUB   = 3'd4;
    localparam logic [2:0] KIND_PSUB  = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_MODIFY, ST_WRITE, ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;     // write zero at sweep address
        logic capture;   // latch request, issue reads
        logic write;     // write back bumped counters
        logic load_out;  // latch read result
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic is_read;
    } t_status;
endpackage

/* rtl/core/repc_ram.sv */
`timescale 1ns / 1ps
module repc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* rtl/core/repc_ctrl.sv */
`timescale 1ns / 1ps
module repc_ctrl import repc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_ready,
    output logic    o_out_valid
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (i_status.clear_done) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_READ;
            ST_READ:   n_state = ST_MODIFY;
            ST_MODIFY: n_state = i_status.is_read ? ST_OUT : ST_WRITE;
            ST_WRITE:  n_state = ST_IDLE;
            ST_OUT:    if (i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_CLEAR:  o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_MODIFY: o_cmd.load_out = i_status.is_read;
            ST_WRITE:  o_cmd.write = 1'b1;
            ST_OUT:    o_out_valid = 1'b1;
            default:   ;
        endcase
    end

    a_no_ready_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_in_ready) else $error("ready during clear");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_write_not_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |-> !i_status.is_read) else $error("write on read request");
endmodule

/* rtl/core/repc_datapath.sv */
`timescale 1ns / 1ps
module repc_datapath import repc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_command,
    input  logic        i_mate,
    input  logic [2:0]  i_read_base,
    input  logic [2:0]  i_ref_base,
    input  logic        i_read_gap,
    input  logic        i_ref_gap,
    input  logic [5:0]  i_quality,
    input  logic        i_last_column,
    input  logic [2:0]  i_counter_kind,
    input  logic [8:0]  i_position,
    output t_status     o_status,
    output logic [31:0] o_count
);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [POS_W-1:0] r_read_pos;
    logic [CLR_W-1:0] r_clr;
    // captured request
    logic r_cmd, r_mate, r_rdgap, r_rfgap, r_last, r_pos_ok, r_mis;
    logic [2:0] r_kind;
    logic [PIDX_W-1:0] r_pidx;
    logic [QUAL_W-1:0] r_q;
    logic [4:0] r_pair;
    logic [31:0] r_count;

    logic [2:0] rd_c, rf_c;
    logic [QUAL_W-1:0] q_c;
    logic [4:0] pair_c;
    logic [PIDX_W-1:0] pidx_c;
    logic pos_ok_c;
    assign rd_c   = (i_read_base < 3'd4) ? i_read_base : 3'd4;
    assign rf_c   = (i_ref_base < 3'd4) ? i_ref_base : 3'd4;
    assign q_c    = (32'(i_quality) < QUALITY_LEVELS) ? QUAL_W'(i_quality)
                                                      : QUAL_W'(QUALITY_LEVELS - 1);
    assign pair_c = 5'(rf_c * 3'd5 + {2'd0, rd_c});
    always_comb begin
        if (i_command) begin
            pos_ok_c = 32'(i_position) < MAX_POSITIONS;
            pidx_c   = PIDX_W'(i_position);
        end else begin
            pos_ok_c = 32'(r_read_pos) < MAX_POSITIONS;
            pidx_c   = PIDX_W'(r_read_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_command; r_mate <= i_mate; r_rdgap <= i_read_gap;
            r_rfgap <= i_ref_gap; r_last <= i_last_column; r_kind <= i_counter_kind;
            r_pidx <= pidx_c; r_pos_ok <= pos_ok_c; r_q <= q_c; r_pair <= pair_c;
            r_mis <= rd_c != rf_c;
        end
    end

    logic [TOT_AW-1:0]  a_tot;
    logic [QUAL_AW-1:0] a_qual;
    logic [SUB_AW-1:0]  a_sub;
    logic [PSUB_AW-1:0] a_psub;
    assign a_tot  = {r_mate, r_pidx};
    assign a_qual = {r_mate, r_pidx, r_q};
    assign a_sub  = SUB_AW'(32'(r_mate) * PAIR_CODES + 32'(r_pair));
    assign a_psub = PSUB_AW'(32'(a_tot) * PAIR_CODES + 32'(r_pair));

    logic [COUNT_WIDTH-1:0] d_tot, d_err, d_cq, d_eq, d_sub, d_psub;
    logic [COUNT_WIDTH-1:0] w_tot, w_err, w_cq, w_eq, w_sub, w_psub;
    logic we_tot, we_err, we_cq, we_eq, we_sub, we_psub, count_ok, clr;

    assign clr      = i_cmd.clear;
    assign count_ok = i_cmd.write && !r_rdgap && !r_rfgap && r_pos_ok;
    assign we_tot   = clr || count_ok;
    assign we_err   = clr || (count_ok && r_mis);
    assign we_eq    = we_err;
    assign we_sub   = we_err;
    assign we_psub  = we_err;
    assign we_cq    = clr || (count_ok && !r_mis);

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (v == CMAX) ? v : v + 1'b1;
    endfunction

    assign w_tot  = clr ? '0 : bump(d_tot);
    assign w_err  = clr ? '0 : bump(d_err);
    assign w_cq   = clr ? '0 : bump(d_cq);
    assign w_eq   = clr ? '0 : bump(d_eq);
    assign w_sub  = clr ? '0 : bump(d_sub);
    assign w_psub = clr ? '0 : bump(d_psub);

    logic [TOT_AW-1:0]  wa_tot;
    logic [QUAL_AW-1:0] wa_qual;
    logic [SUB_AW-1:0]  wa_sub;
    logic [PSUB_AW-1:0] wa_psub;
    assign wa_tot  = clr ? TOT_AW'(r_clr)  : a_tot;
    assign wa_qual = clr ? QUAL_AW'(r_clr) : a_qual;
    assign wa_sub  = clr ? SUB_AW'(r_clr)  : a_sub;
    assign wa_psub = clr ? PSUB_AW'(r_clr) : a_psub;

    repc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TOT_DEPTH)) u_tot (.i_clk,
        .i_we(we_tot && (!clr || 32'(r_clr) < TOT_DEPTH)), .i_waddr(wa_tot),
        .i_wdata(w_tot), .i_raddr(a_tot), .o_rdata(d_tot));
    repc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TOT_DEPTH)) u_err (.i_clk,
        .i_we(we_err && (!clr || 32'(r_clr) < TOT_DEPTH)), .i_waddr(wa_tot),
        .i_wdata(w_err), .i_raddr(a_tot), .o_rdata(d_err));
    repc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(QUAL_DEPTH)) u_cq (.i_clk,
        .i_we(we_cq), .i_waddr(wa_qual), .i_wdata(w_cq), .i_raddr(a_qual),
        .o_rdata(d_cq));
    repc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(QUAL_DEPTH)) u_eq (.i_clk,
        .i_we(we_eq), .i_waddr(wa_qual), .i_wdata(w_eq), .i_raddr(a_qual),
        .o_rdata(d_eq));
    repc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(SUB_DEPTH)) u_sub (.i_clk,
        .i_we(we_sub && (!clr || 32'(r_clr) < SUB_DEPTH)), .i_waddr(wa_sub),
        .i_wdata(w_sub), .i_raddr(a_sub), .o_rdata(d_sub));
    repc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(PSUB_DEPTH)) u_psub (.i_clk,
        .i_we(we_psub && (!clr || 32'(r_clr) < PSUB_DEPTH)), .i_waddr(wa_psub),
        .i_wdata(w_psub), .i_raddr(a_psub), .o_rdata(d_psub));

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (clr && 32'(r_clr) < CLR_DEPTH) begin
            r_clr <= r_clr + 1'b1;
        end
    end
    assign o_status.clear_done = 32'(r_clr) >= CLR_DEPTH - 1;
    assign o_status.is_read    = r_cmd;

    // read position update at write-back
    logic [POS_W-1:0] n_read_pos;
    always_comb begin
        n_read_pos = r_read_pos;
        if (!r_rdgap && 32'(r_read_pos) < MAX_POSITIONS) n_read_pos = r_read_pos + 1'b1;
        if (r_last) n_read_pos = '0;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_pos <= '0;
        end else if (i_cmd.write) begin
            r_read_pos <= n_read_pos;
        end
    end

    logic [COUNT_WIDTH-1:0] sel;
    logic [31:0] sat;
    always_comb begin
        sel = '0;
        case (r_kind)
            KIND_TOTAL: if (r_pos_ok) sel = d_tot;
            KIND_ERROR: if (r_pos_ok) sel = d_err;
            KIND_CQUAL: if (r_pos_ok) sel = d_cq;
            KIND_EQUAL: if (r_pos_ok) sel = d_eq;
            KIND_SUB:   sel = d_sub;
            KIND_PSUB:  if (r_pos_ok) sel = d_psub;
            default:    sel = '0;
        endcase
        if (COUNT_WIDTH > 32) begin
            sat = (64'(sel) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sel);
        end else begin
            sat = 32'(sel);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) r_count <= sat;
    end
    assign o_count = r_count;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_read_pos) <= MAX_POSITIONS) else $error("read position overflow");
    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |-> !i_cmd.write && !i_cmd.capture) else $error("request during clear");
    a_pos_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write && r_last) |=> r_read_pos == '0) else $error("position not cleared");
endmodule

/* rtl/core/read_error_profile_counter.sv */
`timescale 1ns / 1ps
// Channel  Dir  Bits  Contents
// s_axis   in   32    request: command, mate, bases, gaps, quality, last, kind, position
// m_axis   out  32    count for a read request
//
// Every request passes through capture, RAM read, modify, then write back
// for a column or the result cycle for a read, whose count is held until taken.
// The RAM read-modify-write loop sets this order; a new request is taken only once the last is done.
// After reset a clearing pass zeroes all counter RAMs, sweeping 2*MAX_POSITIONS*
// QUALITY_LEVELS addresses (65536), while s_axis_tready stays low.
// A stalled result blocks the next request.
module read_error_profile_counter import repc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: command[0], mate[1], read_base[4:2], ref_base[7:5], read_gap[8],
    // ref_gap[9], quality[15:10], counter_kind[18:16], position[27:19], zero
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // last_column
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // count[31:0]
);
    t_cmd    cmd;
    t_status status;

    repc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid(s_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(status), .o_cmd(cmd), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid)
    );

    repc_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_command(s_axis_tdata[0]), .i_mate(s_axis_tdata[1]),
        .i_read_base(s_axis_tdata[4:2]), .i_ref_base(s_axis_tdata[7:5]),
        .i_read_gap(s_axis_tdata[8]), .i_ref_gap(s_axis_tdata[9]),
        .i_quality(s_axis_tdata[15:10]), .i_last_column(s_axis_tlast),
        .i_counter_kind(s_axis_tdata[18:16]), .i_position(s_axis_tdata[27:19]),
        .o_status(status), .o_count(m_axis_tdata)
    );
endmodule
